[hw/rtl/multi_motor_speed_pid_core_defines.svh]
// Assertion macros for the checks in the top level of the speed controller.
`ifndef MULTI_MOTOR_SPEED_PID_CORE_DEFINES_SVH
`define MULTI_MOTOR_SPEED_PID_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MMSP_ASSERT_IMPL(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error("mmsp check failed");
`define MMSP_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error("mmsp check failed");
`else
`define MMSP_ASSERT_IMPL(label, clock, resetn, ante, cons)
`define MMSP_ASSERT_NEXT(label, clock, resetn, ante, cons)
`endif
`endif

[hw/rtl/mmsp_pkg.sv]
`timescale 1ns / 1ps
package mmsp_pkg;

    localparam int SLOTS  = 4;
    localparam int SLOT_W = 2;
    localparam int ID_W   = 11;
    localparam int WORD_W = 16;
    localparam int ERR_W  = 17;
    localparam int INTEG_W = 24;
    localparam int LAST_W = 18;
    localparam int DIFF_W = 19;
    localparam int DRIVE_W = 15;
    localparam int FRAME_W = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [ID_W-1:0] ID_BASE = 11'h200;
    localparam int DRIVE_MAX = 10000;

    localparam int DEF_MOTORS         = 4;
    localparam int DEF_INTEGRAL_START = 1000;
    localparam int DEF_INTEGRAL_LIMIT = 8000;
    localparam int DEF_GAIN_FRAC_BITS = 8;
    localparam int DEF_QUEUE_DEPTH    = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FOUR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE    = 3'd7;

    localparam logic [WORD_W-1:0] RST_TARGET_ONE   = 16'h0000;
    localparam logic [WORD_W-1:0] RST_TARGET_TWO   = 16'h0000;
    localparam logic [WORD_W-1:0] RST_TARGET_THREE = 16'hEC78;
    localparam logic [WORD_W-1:0] RST_TARGET_FOUR  = 16'h1388;
    localparam logic [WORD_W-1:0] RST_GAIN_PROP    = 16'h0400;
    localparam logic [WORD_W-1:0] RST_GAIN_INTEG   = 16'h0000;
    localparam logic [WORD_W-1:0] RST_GAIN_DERIV   = 16'h0000;
    localparam logic [WORD_W-1:0] RST_DEAD_ZONE    = 16'h000A;

    typedef struct packed {
        logic [SLOTS-1:0][WORD_W-1:0] target;
        logic signed [WORD_W-1:0]     gain_prop;
        logic signed [WORD_W-1:0]     gain_integ;
        logic signed [WORD_W-1:0]     gain_deriv;
        logic [WORD_W-1:0]            dead_zone;
    } cfg_t;

    // One classified feedback item on its way to the arithmetic.
    typedef struct packed {
        logic                     ok;
        logic [SLOT_W-1:0]        slot;
        logic signed [WORD_W-1:0] speed;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

[hw/rtl/mmsp_if.sv]
`timescale 1ns / 1ps
interface mmsp_feedback_if;
    logic               valid;
    logic               ready;
    logic [10:0]        msg_id;
    logic signed [15:0] speed;

    modport source (output valid, output msg_id, output speed, input ready);
    modport sink (input valid, input msg_id, input speed, output ready);
endinterface

interface mmsp_command_if;
    logic               valid;
    logic               ready;
    logic               id_valid;
    logic signed [14:0] drive;
    logic [63:0]        tx_payload;

    modport source (output valid, output id_valid, output drive, output tx_payload,
                    input ready);
    modport sink (input valid, input id_valid, input drive, input tx_payload,
                  output ready);
endinterface

[hw/rtl/mmsp_front.sv]
`timescale 1ns / 1ps
module mmsp_front #(
    parameter int MOTORS = mmsp_pkg::DEF_MOTORS
) (
    mmsp_feedback_if.sink  feedback,
    output mmsp_pkg::job_t push_job,
    output logic           push_valid,
    input  logic           push_ready
);
    import mmsp_pkg::*;

    logic [ID_W-1:0] offset;

    assign offset = feedback.msg_id - ID_BASE - 11'd1;

    always_comb
    begin
        push_job.ok    = (feedback.msg_id > ID_BASE) &&
                         (feedback.msg_id <= ID_BASE + ID_W'(MOTORS));
        push_job.slot  = offset[SLOT_W-1:0];
        push_job.speed = feedback.speed;
    end

    assign push_valid     = feedback.valid;
    assign feedback.ready = push_ready;

endmodule

[hw/rtl/mmsp_queue.sv]
`timescale 1ns / 1ps
module mmsp_queue #(
    parameter int DEPTH = mmsp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mmsp_pkg::job_t        push_job,
    input  logic                  push_valid,
    output logic                  push_ready,
    output mmsp_pkg::job_t        pop_job,
    input  logic                  pop,
    output mmsp_pkg::queue_stat_t stat
);
    import mmsp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign push_ready = !stat.full;
    assign push       = push_valid && !stat.full;
    assign pop_job    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/mmsp_back.sv]
`timescale 1ns / 1ps
module mmsp_back #(
    parameter int MOTORS         = mmsp_pkg::DEF_MOTORS,
    parameter int INTEGRAL_START = mmsp_pkg::DEF_INTEGRAL_START,
    parameter int INTEGRAL_LIMIT = mmsp_pkg::DEF_INTEGRAL_LIMIT,
    parameter int GAIN_FRAC_BITS = mmsp_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mmsp_pkg::cfg_t   cfg,
    input  mmsp_pkg::job_t   job,
    input  logic             job_valid,
    output logic             pop,
    mmsp_command_if.source   command
);
    import mmsp_pkg::*;

    localparam int PP_W  = WORD_W + ERR_W;
    localparam int PI_W  = WORD_W + INTEG_W;
    localparam int PD_W  = WORD_W + DIFF_W;
    localparam int SUM_W = PI_W + 2;

    localparam logic signed [LAST_W-1:0]  START_P = LAST_W'(INTEGRAL_START);
    localparam logic signed [INTEG_W:0]   LIM_P   = (INTEG_W + 1)'(INTEGRAL_LIMIT);
    localparam logic signed [INTEG_W:0]   LIM_N   = -LIM_P;
    localparam logic signed [SUM_W-1:0]   BIAS    = SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
    localparam logic signed [SUM_W-1:0]   Q_MAX   = SUM_W'(DRIVE_MAX);
    localparam logic signed [SUM_W-1:0]   Q_MIN   = -Q_MAX;

    logic en;

    // Per-motor state.
    logic signed [INTEG_W-1:0] integ_reg [MOTORS];
    logic signed [LAST_W-1:0]  last_reg  [MOTORS];
    logic signed [WORD_W-1:0]  cmd_reg   [MOTORS];

    // Head of queue: error, dead zone and integral update.
    logic signed [WORD_W-1:0]  target_sel;
    logic signed [INTEG_W-1:0] integ_old;
    logic signed [LAST_W-1:0]  last_old;
    logic signed [ERR_W-1:0]   err_raw;
    logic signed [LAST_W-1:0]  err_wide;
    logic signed [LAST_W-1:0]  dz_pos;
    logic                      in_dz;
    logic signed [ERR_W-1:0]   err_eff;
    logic signed [LAST_W-1:0]  err_eff_wide;
    logic signed [INTEG_W-1:0] integ_base;
    logic signed [LAST_W-1:0]  last_base;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_clamped;
    logic signed [INTEG_W-1:0] integ_new;
    logic signed [DIFF_W-1:0]  diff_new;
    logic                      state_we;

    logic                      s1_valid_reg, s1_valid_next;
    logic                      s1_ok_reg;
    logic [SLOT_W-1:0]         s1_slot_reg;
    logic signed [ERR_W-1:0]   s1_err_reg;
    logic signed [INTEG_W-1:0] s1_integ_reg;
    logic signed [DIFF_W-1:0]  s1_diff_reg;

    logic                      s2_valid_reg;
    logic                      s2_ok_reg;
    logic [SLOT_W-1:0]         s2_slot_reg;
    logic signed [PP_W-1:0]    s2_pp_reg, s2_pp_next;
    logic signed [PI_W-1:0]    s2_pi_reg, s2_pi_next;
    logic signed [PD_W-1:0]    s2_pd_reg, s2_pd_next;

    logic                      s3_valid_reg;
    logic                      s3_ok_reg;
    logic [SLOT_W-1:0]         s3_slot_reg;
    logic signed [SUM_W-1:0]   s3_sum_reg, s3_sum_next;

    logic signed [SUM_W-1:0]   biased;
    logic signed [SUM_W-1:0]   quot;
    logic signed [SUM_W-1:0]   q_clamped;
    logic signed [WORD_W-1:0]  cmd_new;
    logic                      cmd_we;

    logic                      out_valid_reg, out_valid_next;
    logic                      out_id_valid_reg, out_id_valid_next;
    logic signed [DRIVE_W-1:0] out_drive_reg, out_drive_next;
    logic [FRAME_W-1:0]        out_frame_reg, out_frame_next;

    // The whole back end advances together; the output register is its last stage.
    assign en  = !out_valid_reg || command.ready;
    assign pop = en && job_valid;

    always_comb
    begin
        target_sel = '0;
        integ_old  = '0;
        last_old   = '0;
        for (int n = 0; n < SLOTS; n++)
        begin
            if (job.slot == SLOT_W'(n))
            begin
                target_sel = $signed(cfg.target[n]);
            end
        end
        for (int n = 0; n < MOTORS; n++)
        begin
            if (job.slot == SLOT_W'(n))
            begin
                integ_old = integ_reg[n];
                last_old  = last_reg[n];
            end
        end
    end

    always_comb
    begin
        err_raw      = ERR_W'(target_sel) - ERR_W'(job.speed);
        err_wide     = LAST_W'(err_raw);
        dz_pos       = $signed({2'b00, cfg.dead_zone});
        in_dz        = (err_wide > -dz_pos) && (err_wide < dz_pos);
        err_eff      = in_dz ? '0 : err_raw;
        integ_base   = in_dz ? '0 : integ_old;
        last_base    = in_dz ? '0 : last_old;
        err_eff_wide = LAST_W'(err_eff);
        integ_sum    = (INTEG_W + 1)'(integ_base) + (INTEG_W + 1)'(err_eff);
        if (integ_sum > LIM_P)
        begin
            integ_clamped = INTEG_W'(LIM_P);
        end
        else if (integ_sum < LIM_N)
        begin
            integ_clamped = INTEG_W'(LIM_N);
        end
        else
        begin
            integ_clamped = integ_sum[INTEG_W-1:0];
        end
        // Integral separation: far from target the integral is held.
        if ((err_eff_wide > -START_P) && (err_eff_wide < START_P))
        begin
            integ_new = integ_clamped;
        end
        else
        begin
            integ_new = integ_base;
        end
        diff_new = DIFF_W'(err_eff) - DIFF_W'(last_base);
        state_we = pop && job.ok;
    end

    assign s1_valid_next = en ? job_valid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < MOTORS; n++)
            begin
                integ_reg[n] <= '0;
                last_reg[n]  <= '0;
            end
        end
        else
        begin
            for (int n = 0; n < MOTORS; n++)
            begin
                if (state_we && (job.slot == SLOT_W'(n)))
                begin
                    integ_reg[n] <= integ_new;
                    last_reg[n]  <= err_eff_wide;
                end
            end
        end
    end

    // Stage two: the three gain products.
    assign s2_pp_next = cfg.gain_prop * s1_err_reg;
    assign s2_pi_next = cfg.gain_integ * s1_integ_reg;
    assign s2_pd_next = cfg.gain_deriv * s1_diff_reg;

    // Stage three: exact sum.
    assign s3_sum_next = SUM_W'(s2_pp_reg) + SUM_W'(s2_pi_reg) + SUM_W'(s2_pd_reg);

    // Stage four: scale toward zero, clamp and update the frame.
    always_comb
    begin
        biased = s3_sum_reg + (s3_sum_reg[SUM_W-1] ? BIAS : '0);
        quot   = biased >>> GAIN_FRAC_BITS;
        if (quot > Q_MAX)
        begin
            q_clamped = Q_MAX;
        end
        else if (quot < Q_MIN)
        begin
            q_clamped = Q_MIN;
        end
        else
        begin
            q_clamped = quot;
        end
        cmd_new = s3_ok_reg ? q_clamped[WORD_W-1:0] : '0;
        cmd_we  = en && s3_valid_reg && s3_ok_reg;
    end

    always_comb
    begin
        out_frame_next = '0;
        for (int n = 0; n < MOTORS; n++)
        begin
            if (s3_ok_reg && (s3_slot_reg == SLOT_W'(n)))
            begin
                out_frame_next[FRAME_W-1-WORD_W*n -: WORD_W] = cmd_new;
            end
            else
            begin
                out_frame_next[FRAME_W-1-WORD_W*n -: WORD_W] = cmd_reg[n];
            end
        end
        out_id_valid_next = s3_ok_reg;
        out_drive_next    = cmd_new[DRIVE_W-1:0];
        out_valid_next    = en ? s3_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int n = 0; n < MOTORS; n++)
            begin
                cmd_reg[n] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (en)
            begin
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
            for (int n = 0; n < MOTORS; n++)
            begin
                if (cmd_we && (s3_slot_reg == SLOT_W'(n)))
                begin
                    cmd_reg[n] <= cmd_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ok_reg        <= job.ok;
            s1_slot_reg      <= job.slot;
            s1_err_reg       <= err_eff;
            s1_integ_reg     <= integ_new;
            s1_diff_reg      <= diff_new;
            s2_ok_reg        <= s1_ok_reg;
            s2_slot_reg      <= s1_slot_reg;
            s2_pp_reg        <= s2_pp_next;
            s2_pi_reg        <= s2_pi_next;
            s2_pd_reg        <= s2_pd_next;
            s3_ok_reg        <= s2_ok_reg;
            s3_slot_reg      <= s2_slot_reg;
            s3_sum_reg       <= s3_sum_next;
            out_id_valid_reg <= out_id_valid_next;
            out_drive_reg    <= out_drive_next;
            out_frame_reg    <= out_frame_next;
        end
    end

    assign command.valid      = out_valid_reg;
    assign command.id_valid   = out_id_valid_reg;
    assign command.drive      = out_drive_reg;
    assign command.tx_payload = out_frame_reg;

endmodule

[hw/rtl/multi_motor_speed_pid_core.sv]
`timescale 1ns / 1ps
// Speed PID for up to four motors fed by CAN feedback frames. Each accepted item
// (identifier and measured speed) yields exactly one result: the new clamped drive
// of the selected motor and the whole 8-byte command frame, or a flagged result
// with the unchanged frame when the identifier selects no motor. A new item can
// be accepted every cycle while the receiver takes results; the per-motor
// integral and last error are read and rewritten in the same cycle at the head of
// the arithmetic pipeline, which sets that rate. An item passes the input queue,
// the s1, s2 and s3 stages and the output register before its result is offered
// on the command side; a receiver stall holds the pipeline and a full input queue
// holds off the feedback side. The user must write targets, gains and dead zone
// through the configuration port while no item is in flight; the block does not enforce it.
`include "multi_motor_speed_pid_core_defines.svh"
module multi_motor_speed_pid_core #(
    parameter int MOTORS         = mmsp_pkg::DEF_MOTORS,
    parameter int INTEGRAL_START = mmsp_pkg::DEF_INTEGRAL_START,
    parameter int INTEGRAL_LIMIT = mmsp_pkg::DEF_INTEGRAL_LIMIT,
    parameter int GAIN_FRAC_BITS = mmsp_pkg::DEF_GAIN_FRAC_BITS,
    parameter int QUEUE_DEPTH    = mmsp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mmsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mmsp_pkg::WORD_W-1:0]        cfg_data,
    mmsp_feedback_if.sink                      feedback,
    mmsp_command_if.source                     command
);
    import mmsp_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    job_t        push_job;
    logic        push_valid;
    logic        push_ready;
    job_t        pop_job;
    logic        pop;
    queue_stat_t q_stat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET_ONE:   cfg_next.target[0]  = cfg_data;
                REG_TARGET_TWO:   cfg_next.target[1]  = cfg_data;
                REG_TARGET_THREE: cfg_next.target[2]  = cfg_data;
                REG_TARGET_FOUR:  cfg_next.target[3]  = cfg_data;
                REG_GAIN_PROP:    cfg_next.gain_prop  = $signed(cfg_data);
                REG_GAIN_INTEG:   cfg_next.gain_integ = $signed(cfg_data);
                REG_GAIN_DERIV:   cfg_next.gain_deriv = $signed(cfg_data);
                REG_DEAD_ZONE:    cfg_next.dead_zone  = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target[0]  <= RST_TARGET_ONE;
            cfg_reg.target[1]  <= RST_TARGET_TWO;
            cfg_reg.target[2]  <= RST_TARGET_THREE;
            cfg_reg.target[3]  <= RST_TARGET_FOUR;
            cfg_reg.gain_prop  <= $signed(RST_GAIN_PROP);
            cfg_reg.gain_integ <= $signed(RST_GAIN_INTEG);
            cfg_reg.gain_deriv <= $signed(RST_GAIN_DERIV);
            cfg_reg.dead_zone  <= RST_DEAD_ZONE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mmsp_front #(
        .MOTORS(MOTORS)
    ) u_front (
        .feedback  (feedback),
        .push_job  (push_job),
        .push_valid(push_valid),
        .push_ready(push_ready)
    );

    mmsp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_job  (push_job),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .pop_job   (pop_job),
        .pop       (pop),
        .stat      (q_stat)
    );

    mmsp_back #(
        .MOTORS        (MOTORS),
        .INTEGRAL_START(INTEGRAL_START),
        .INTEGRAL_LIMIT(INTEGRAL_LIMIT),
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .job      (pop_job),
        .job_valid(!q_stat.empty),
        .pop      (pop),
        .command  (command)
    );

    // A flagged item never carries a drive value.
    `MMSP_ASSERT_IMPL(a_invalid_zero, clk, rst_n, command.valid && !command.id_valid, command.drive == 15'sd0)
    // The drive never leaves the clamp range.
    `MMSP_ASSERT_IMPL(a_drive_range, clk, rst_n, command.valid, (command.drive <= 15'sd10000) && (command.drive >= -15'sd10000))
    // A full queue holds off the feedback side.
    `MMSP_ASSERT_IMPL(a_full_stalls, clk, rst_n, q_stat.full, !feedback.ready)
    // Nothing is popped from an empty queue.
    `MMSP_ASSERT_IMPL(a_no_empty_pop, clk, rst_n, q_stat.empty, !pop)

endmodule

[test/tb_multi_motor_speed_pid_core.sv]
`timescale 1ns / 1ps
import mmsp_pkg::*;

typedef struct packed {
    logic        id_valid;
    logic [14:0] drive;
    logic [63:0] tx_payload;
} pid_command_t;

class speed_pid_tracker;
    logic [WORD_W-1:0] regs [8];
    longint            integ [SLOTS];
    longint            last_err [SLOTS];
    logic [WORD_W-1:0] cmd_word [SLOTS];
    pid_command_t      pending_commands [$];
    int                errors;

    function new();
        regs[REG_TARGET_ONE]   = RST_TARGET_ONE;
        regs[REG_TARGET_TWO]   = RST_TARGET_TWO;
        regs[REG_TARGET_THREE] = RST_TARGET_THREE;
        regs[REG_TARGET_FOUR]  = RST_TARGET_FOUR;
        regs[REG_GAIN_PROP]    = RST_GAIN_PROP;
        regs[REG_GAIN_INTEG]   = RST_GAIN_INTEG;
        regs[REG_GAIN_DERIV]   = RST_GAIN_DERIV;
        regs[REG_DEAD_ZONE]    = RST_DEAD_ZONE;
        for (int n = 0; n < SLOTS; n++)
        begin
            integ[n]    = 0;
            last_err[n] = 0;
            cmd_word[n] = '0;
        end
        errors = 0;
    endfunction

    function void write_reg(int idx, logic [WORD_W-1:0] value);
        regs[idx] = value;
    endfunction

    function logic [FRAME_W-1:0] frame();
        logic [FRAME_W-1:0] f;
        f = '0;
        for (int n = 0; n < SLOTS; n++)
            f[FRAME_W-1-WORD_W*n -: WORD_W] = cmd_word[n];
        return f;
    endfunction

    function int pending();
        return pending_commands.size();
    endfunction

    // Works out the command that one accepted feedback item must produce.
    function void note_feedback(logic [ID_W-1:0] id, logic signed [WORD_W-1:0] speed);
        pid_command_t c;
        int           m;
        longint       err, acc, dz, kp, ki, kd, sum, q;
        if (int'(id) <= int'(ID_BASE) || int'(id) > int'(ID_BASE) + DEF_MOTORS)
        begin
            c.id_valid   = 1'b0;
            c.drive      = '0;
            c.tx_payload = frame();
        end
        else
        begin
            m   = int'(id) - int'(ID_BASE) - 1;
            err = longint'($signed(regs[m])) - longint'(speed);
            acc = integ[m];
            dz  = longint'(regs[REG_DEAD_ZONE]);
            if (err > -dz && err < dz)
            begin
                err         = 0;
                acc         = 0;
                last_err[m] = 0;
            end
            // The integral only moves while the error is small.
            if (err > -DEF_INTEGRAL_START && err < DEF_INTEGRAL_START)
            begin
                acc += err;
                if (acc > DEF_INTEGRAL_LIMIT)
                    acc = DEF_INTEGRAL_LIMIT;
                else if (acc < -DEF_INTEGRAL_LIMIT)
                    acc = -DEF_INTEGRAL_LIMIT;
            end
            kp  = longint'($signed(regs[REG_GAIN_PROP]));
            ki  = longint'($signed(regs[REG_GAIN_INTEG]));
            kd  = longint'($signed(regs[REG_GAIN_DERIV]));
            sum = kp * err + ki * acc + kd * (err - last_err[m]);
            q   = sum / (longint'(1) << DEF_GAIN_FRAC_BITS);
            if (q > DRIVE_MAX)
                q = DRIVE_MAX;
            if (q < -DRIVE_MAX)
                q = -DRIVE_MAX;
            integ[m]     = acc;
            last_err[m]  = err;
            cmd_word[m]  = q[WORD_W-1:0];
            c.id_valid   = 1'b1;
            c.drive      = q[DRIVE_W-1:0];
            c.tx_payload = frame();
        end
        pending_commands.push_back(c);
    endfunction

    task flag_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    task check_command(logic id_valid, logic [DRIVE_W-1:0] drive,
                       logic [FRAME_W-1:0] tx_payload);
        pid_command_t want;
        if (pending_commands.size() == 0)
        begin
            flag_mismatch("command item with no feedback item waiting");
        end
        else
        begin
            want = pending_commands.pop_front();
            if (id_valid !== want.id_valid)
                flag_mismatch($sformatf("id_valid got %b want %b", id_valid, want.id_valid));
            if (drive !== want.drive)
                flag_mismatch($sformatf("drive got %0d want %0d",
                                        $signed(drive), $signed(want.drive)));
            if (tx_payload !== want.tx_payload)
                flag_mismatch($sformatf("tx_payload got %h want %h",
                                        tx_payload, want.tx_payload));
        end
    endtask
endclass

module tb_multi_motor_speed_pid_core;

    localparam int STALL_LIMIT     = 1000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int PHASES          = 10;
    localparam int PHASE_ITEMS     = 108;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    mmsp_feedback_if fb ();
    mmsp_command_if  cmd_if ();

    multi_motor_speed_pid_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .feedback  (fb),
        .command   (cmd_if)
    );

    speed_pid_tracker tracker = new();

    int                gap_pct   = 0;
    int                stall_pct = 0;
    bit                hold_req  = 1'b0;
    int                hold_left = 0;
    int                quiet_cycles = 0;
    int                bias;
    logic [WORD_W-1:0] next_regs [8];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        cmd_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                cmd_if.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req      = 1'b0;
                hold_left     = HOLD_OFF_CYCLES - 1;
                cmd_if.ready <= 1'b0;
            end
            else
            begin
                cmd_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (fb.valid && fb.ready)
                tracker.note_feedback(fb.msg_id, fb.speed);
            if (cmd_if.valid && cmd_if.ready)
                tracker.check_command(cmd_if.id_valid, cmd_if.drive, cmd_if.tx_payload);
            if ((fb.valid && fb.ready) || (cmd_if.valid && cmd_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task send_feedback(logic [ID_W-1:0] id, logic signed [WORD_W-1:0] speed);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            fb.valid <= 1'b0;
        end
        @(negedge clk);
        fb.valid  <= 1'b1;
        fb.msg_id <= id;
        fb.speed  <= speed;
        do
            @(posedge clk);
        while (fb.ready !== 1'b1);
    endtask

    task wait_idle();
        @(negedge clk);
        fb.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task program_settings();
        for (int i = int'(REG_TARGET_ONE); i <= int'(REG_DEAD_ZONE); i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= next_regs[i];
            tracker.write_reg(i, next_regs[i]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function logic [WORD_W-1:0] pick_gain();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return WORD_W'($urandom_range(0, 1024));
            4: return WORD_W'(-int'($urandom_range(0, 512)));
            default: return WORD_W'($urandom);
        endcase
    endfunction

    function logic [WORD_W-1:0] pick_target();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return WORD_W'($urandom);
            default: return WORD_W'(int'($urandom_range(0, 16000)) - 8000);
        endcase
    endfunction

    function logic [WORD_W-1:0] pick_dead_zone();
        case ($urandom_range(7))
            0: return '0;
            1: return 16'hFFFF;
            2: return WORD_W'($urandom);
            default: return WORD_W'($urandom_range(0, 60));
        endcase
    endfunction

    task send_random_item();
        logic [ID_W-1:0]   id;
        logic [WORD_W-1:0] spd;
        int                r;
        int                m;
        int                s;
        r = $urandom_range(99);
        if (r < 80)
            id = ID_BASE + ID_W'($urandom_range(1, DEF_MOTORS));
        else if (r < 86)
            id = ($urandom_range(1) == 0) ? ID_BASE : ID_BASE + ID_W'(DEF_MOTORS + 1);
        else
            id = ID_W'($urandom);
        m = int'(id) - int'(ID_BASE) - 1;
        if (m >= 0 && m < SLOTS && $urandom_range(99) < 75)
        begin
            // Mostly near the target, so the dead zone and integral get exercised.
            s = int'($signed(tracker.regs[m])) + bias + int'($urandom_range(0, 800)) - 400;
            if (s > 32767)
                s = 32767;
            if (s < -32768)
                s = -32768;
            spd = WORD_W'(s);
        end
        else
        begin
            spd = WORD_W'($urandom);
        end
        send_feedback(id, spd);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        fb.valid  = 1'b0;
        fb.msg_id = '0;
        fb.speed  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: invalid ids, dead zone edges and saturation.
        send_feedback(11'h000, 16'sd0);
        send_feedback(ID_BASE, 16'sd0);
        send_feedback(ID_BASE + 11'd5, 16'sd100);
        send_feedback(11'h7FF, -16'sd1);
        send_feedback(ID_BASE + 11'd1, 16'sd5);
        send_feedback(ID_BASE + 11'd1, 16'sd500);
        send_feedback(ID_BASE + 11'd2, -16'sd32768);
        send_feedback(ID_BASE + 11'd3, 16'sd32767);
        send_feedback(ID_BASE + 11'd4, 16'sd5000);
        send_feedback(ID_BASE + 11'd4, 16'sd4990);
        send_feedback(ID_BASE + 11'd4, 16'sd5010);
        send_feedback(ID_BASE + 11'd4, 16'sd4991);
        wait_idle();

        // Extreme targets and gains with no dead zone.
        next_regs[REG_TARGET_ONE]   = 16'h7FFF;
        next_regs[REG_TARGET_TWO]   = 16'h8000;
        next_regs[REG_TARGET_THREE] = 16'h0000;
        next_regs[REG_TARGET_FOUR]  = 16'd1000;
        next_regs[REG_GAIN_PROP]    = 16'h7FFF;
        next_regs[REG_GAIN_INTEG]   = 16'h8000;
        next_regs[REG_GAIN_DERIV]   = 16'h7FFF;
        next_regs[REG_DEAD_ZONE]    = 16'h0000;
        program_settings();
        send_feedback(ID_BASE + 11'd1, -16'sd32768);
        send_feedback(ID_BASE + 11'd2, 16'sd32767);
        send_feedback(ID_BASE + 11'd3, 16'sd0);
        send_feedback(ID_BASE + 11'd4, 16'sd1);
        send_feedback(ID_BASE + 11'd4, 16'sd0);
        send_feedback(ID_BASE + 11'd4, 16'sd2000);
        send_feedback(ID_BASE + 11'd4, -16'sd999);
        wait_idle();

        // Widest dead zone with the opposite gain extremes.
        next_regs[REG_GAIN_PROP]  = 16'h8000;
        next_regs[REG_GAIN_INTEG] = 16'h7FFF;
        next_regs[REG_GAIN_DERIV] = 16'h8000;
        next_regs[REG_DEAD_ZONE]  = 16'hFFFF;
        program_settings();
        send_feedback(ID_BASE + 11'd1, -16'sd32768);
        send_feedback(ID_BASE + 11'd2, 16'sd32767);
        send_feedback(ID_BASE + 11'd3, 16'sd100);
        send_feedback(ID_BASE + 11'd5, 16'sd0);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            for (int i = int'(REG_TARGET_ONE); i <= int'(REG_TARGET_FOUR); i++)
                next_regs[i] = pick_target();
            next_regs[REG_GAIN_PROP]  = pick_gain();
            next_regs[REG_GAIN_INTEG] = pick_gain();
            next_regs[REG_GAIN_DERIV] = pick_gain();
            next_regs[REG_DEAD_ZONE]  = pick_dead_zone();
            program_settings();
            bias = int'($urandom_range(0, 1800)) - 900;
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 58; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 58; end
                default: begin gap_pct = 24; stall_pct = 24; end
            endcase
            // One phase keeps offering items while the receiver holds off.
            if (p == 5)
            begin
                gap_pct  = 0;
                hold_req = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_random_item();
            wait_idle();
        end

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/mmsp_pkg.sv
hw/rtl/mmsp_if.sv
hw/rtl/mmsp_front.sv
hw/rtl/mmsp_queue.sv
hw/rtl/mmsp_back.sv
hw/rtl/multi_motor_speed_pid_core.sv
test/tb_multi_motor_speed_pid_core.sv
